// File: design/tile_scroll_wrap_clip_defines.svh
`ifndef TILE_SCROLL_WRAP_CLIP_DEFINES_SVH
`define TILE_SCROLL_WRAP_CLIP_DEFINES_SVH

// checked while out of reset
`define TSWC_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TSWC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/tswc_pkg.sv
`timescale 1ns / 1ps

package tswc_pkg;

   localparam int TILE_WIDTH  = 16;
   localparam int TILE_HEIGHT = 16;
   localparam int MAP_COLS    = 26;
   localparam int MAP_ROWS    = 20;

   localparam int PLANE_W = MAP_COLS * TILE_WIDTH;
   localparam int PLANE_H = MAP_ROWS * TILE_HEIGHT;
   localparam int PLANE_MAX = (PLANE_W > PLANE_H) ? PLANE_W : PLANE_H;
   localparam int TILE_MAX  = (TILE_WIDTH > TILE_HEIGHT) ? TILE_WIDTH : TILE_HEIGHT;

   localparam int IDX_W    = 5;
   localparam int SCROLL_W = 16;
   localparam int CFG_W    = 10;
   localparam int DEST_W   = 11;
   localparam int SRC_W    = 4;
   localparam int SIZE_W   = 5;
   localparam int ADDR_W   = 3;

   // signed offset width: idx*tile - scroll, and the biased value for the modulo
   localparam int MW = 18;

   // bias that makes any offset positive before the modulo
   localparam int KP_X = ((2 ** (MW - 1) + PLANE_W - 1) / PLANE_W) * PLANE_W;
   localparam int KP_Y = ((2 ** (MW - 1) + PLANE_H - 1) / PLANE_H) * PLANE_H;

   // floor(2^MW / P): quotient is exact or one low
   localparam int RECIP_X = (2 ** MW) / PLANE_W;
   localparam int RECIP_Y = (2 ** MW) / PLANE_H;
   localparam int RECIP_MAX = (RECIP_X > RECIP_Y) ? RECIP_X : RECIP_Y;

   localparam int TW = $clog2(TILE_MAX + 1);
   localparam int PW = $clog2(PLANE_MAX + 1);
   localparam int RW = $clog2(RECIP_MAX + 1);
   localparam int BW = $clog2(2 ** CFG_W + PLANE_MAX);
   localparam int DW = BW + 2;

   localparam int REQ_FIELDS_W = 2 * IDX_W + 2 * SCROLL_W;
   localparam int RSP_FIELDS_W = 2 + 2 * DEST_W + 2 * SRC_W + 2 * SIZE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [ADDR_W-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_CLIP_L   = 3'd2,
      REG_CLIP_T   = 3'd3,
      REG_CLIP_W   = 3'd4,
      REG_CLIP_H   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [TW-1:0] tile;
      logic [PW-1:0] plane;
      logic [MW-1:0] kp;
      logic [RW-1:0] recip;
   } axis_const_type;

   localparam axis_const_type AXIS_X = '{
      tile: TW'(TILE_WIDTH), plane: PW'(PLANE_W), kp: MW'(KP_X), recip: RW'(RECIP_X)};
   localparam axis_const_type AXIS_Y = '{
      tile: TW'(TILE_HEIGHT), plane: PW'(PLANE_H), kp: MW'(KP_Y), recip: RW'(RECIP_Y)};

   typedef struct packed {
      logic [CFG_W-1:0] base_x;
      logic [CFG_W-1:0] base_y;
      logic [BW-1:0]    lo_x;
      logic [BW-1:0]    hi_x;
      logic [BW-1:0]    lo_y;
      logic [BW-1:0]    hi_y;
   } bounds_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } stage_en_type;

endpackage

// File: design/tswc_cfg.sv
`timescale 1ns / 1ps

module tswc_cfg import tswc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wen,
   input  logic [ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata,
   output bounds_type        bounds
);

   logic [CFG_W-1:0] base_x_ff, base_y_ff, clip_l_ff, clip_t_ff, clip_w_ff, clip_h_ff;
   bounds_type       bounds_ff, bounds_in;
   logic             clip_on;
   logic [BW-1:0]    plane_hi_x, plane_hi_y, clip_hi_x, clip_hi_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= '0;
         base_y_ff <= '0;
         clip_l_ff <= '0;
         clip_t_ff <= '0;
         clip_w_ff <= '0;
         clip_h_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_ORIGIN_X: base_x_ff <= csr_wdata;
            REG_ORIGIN_Y: base_y_ff <= csr_wdata;
            REG_CLIP_L:   clip_l_ff <= csr_wdata;
            REG_CLIP_T:   clip_t_ff <= csr_wdata;
            REG_CLIP_W:   clip_w_ff <= csr_wdata;
            REG_CLIP_H:   clip_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      clip_on    = (clip_w_ff != '0) && (clip_h_ff != '0);
      plane_hi_x = BW'(base_x_ff) + BW'(PLANE_W);
      plane_hi_y = BW'(base_y_ff) + BW'(PLANE_H);
      clip_hi_x  = BW'(clip_l_ff) + BW'(clip_w_ff);
      clip_hi_y  = BW'(clip_t_ff) + BW'(clip_h_ff);

      bounds_in.base_x = base_x_ff;
      bounds_in.base_y = base_y_ff;
      bounds_in.lo_x = (clip_on && clip_l_ff > base_x_ff) ? BW'(clip_l_ff) : BW'(base_x_ff);
      bounds_in.lo_y = (clip_on && clip_t_ff > base_y_ff) ? BW'(clip_t_ff) : BW'(base_y_ff);
      bounds_in.hi_x = (clip_on && clip_hi_x < plane_hi_x) ? clip_hi_x : plane_hi_x;
      bounds_in.hi_y = (clip_on && clip_hi_y < plane_hi_y) ? clip_hi_y : plane_hi_y;
   end

   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign bounds = bounds_ff;

endmodule

// File: design/tswc_wrap.sv
`timescale 1ns / 1ps

module tswc_wrap import tswc_pkg::*; (
   input  logic                       clock,
   input  stage_en_type               en,
   input  axis_const_type             k,
   input  logic [IDX_W-1:0]           idx,
   input  logic signed [SCROLL_W-1:0] scroll,
   input  logic [CFG_W-1:0]           origin,
   output logic signed [DW-1:0]       pos
);

   // s1: raw offset and biased modulo operand
   logic signed [MW-1:0] m_in, m1_ff, m2_ff, ma;
   logic                 big_in, neg_in, big1_ff, neg1_ff, big2_ff, neg2_ff;
   logic [MW-1:0]        x_in, x1_ff, x2_ff;
   // s2: quotient estimate
   logic [MW+RW-1:0]     prod;
   logic [RW-1:0]        q_in, q_ff;
   // s3: remainder and wrap select
   logic [MW-1:0]        qp, r0, rs;
   logic signed [MW-1:0] mw_in, mw_ff;
   // s4: screen position
   logic signed [DW-1:0] pos_in, pos_ff;

   always_comb begin
      m_in   = $signed(MW'(idx) * MW'(k.tile)) - MW'(scroll);
      big_in = m_in >= $signed(MW'(k.plane));
      neg_in = m_in < -$signed(MW'(k.tile));
      ma     = big_in ? m_in : m_in + $signed(MW'(k.tile));
      x_in   = MW'(ma) + k.kp;
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         m1_ff   <= m_in;
         big1_ff <= big_in;
         neg1_ff <= neg_in;
         x1_ff   <= x_in;
      end
   end

   always_comb begin
      prod = (MW+RW)'(x1_ff) * (MW+RW)'(k.recip);
      q_in = prod[MW+RW-1:MW];
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         q_ff    <= q_in;
         m2_ff   <= m1_ff;
         big2_ff <= big1_ff;
         neg2_ff <= neg1_ff;
         x2_ff   <= x1_ff;
      end
   end

   always_comb begin
      qp = MW'(q_ff) * MW'(k.plane);
      r0 = x2_ff - qp;
      rs = (r0 >= MW'(k.plane)) ? r0 - MW'(k.plane) : r0;
      priority if (big2_ff) mw_in = $signed(rs);
      else if (neg2_ff)     mw_in = $signed(rs) - $signed(MW'(k.tile));
      else                  mw_in = m2_ff;
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         mw_ff <= mw_in;
      end
   end

   assign pos_in = $signed(DW'(origin)) + DW'(mw_ff);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// File: design/tswc_clip.sv
`timescale 1ns / 1ps

module tswc_clip import tswc_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] pos,
   input  logic [TW-1:0]        tile,
   input  logic [BW-1:0]        lo,
   input  logic [BW-1:0]        hi,
   output logic                 drawn,
   output logic                 full,
   output logic [DEST_W-1:0]    dst,
   output logic [SRC_W-1:0]     src,
   output logic [SIZE_W-1:0]    size
);

   logic signed [DW-1:0] lo_s, hi_s, t_s, s, d1, w;
   logic                 under;
   logic                 drawn_ff, full_ff;
   logic [DEST_W-1:0]    dst_ff;
   logic [SRC_W-1:0]     src_ff;
   logic [SIZE_W-1:0]    size_ff;

   // dst + clipped width ends at pos + tile, or at hi when pos + tile passes hi
   always_comb begin
      lo_s  = $signed(DW'(lo));
      hi_s  = $signed(DW'(hi));
      t_s   = $signed(DW'(tile));
      under = pos < lo_s;
      s     = under ? lo_s - pos : '0;
      d1    = under ? lo_s : pos;
      w     = (pos + t_s > hi_s) ? hi_s - d1 : t_s - s;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         drawn_ff <= w > 0;
         full_ff  <= (s == '0) && (w == t_s);
         dst_ff   <= d1[DEST_W-1:0];
         src_ff   <= s[SRC_W-1:0];
         size_ff  <= w[SIZE_W-1:0];
      end
   end

   assign drawn = drawn_ff;
   assign full  = full_ff;
   assign dst   = dst_ff;
   assign src   = src_ff;
   assign size  = size_ff;

endmodule

// File: design/tile_scroll_wrap_clip.sv
`timescale 1ns / 1ps
`include "tile_scroll_wrap_clip_defines.svh"

// channel | ports          | fields, low bit first
// --------+----------------+---------------------------------------------------------
// req     | req_tdata[47:0]| tile_col 5, tile_row 5, scroll_horiz 16, scroll_vert 16
// rsp     | rsp_tdata[47:0]| visible 1, dest_x 11, dest_y 11, src_x 4, src_y 4,
//         |                | src_w 5, src_h 5, partial 1
// csr     | csr_wen/addr   | write only, index 0..5, 10-bit data
//
// One beat per cycle while rsp_tready does not stall the pipeline.
// Stages: offset, reciprocal multiply, remainder/wrap, origin add, clip.
// Synchronous active-high reset empties the pipeline and zeroes the csr registers.
// Each stage holds on stall unless the one after it is empty; bubbles close up.

module tile_scroll_wrap_clip import tswc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // tile_col, tile_row, scroll_horiz, scroll_vert
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // visible, dest_x, dest_y, src_x, src_y,
                                             // src_w, src_h, partial
   input  logic                  csr_wen,
   input  logic [ADDR_W-1:0]     csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   logic [4:0]                  valid_ff, valid_in;
   stage_en_type                en;
   bounds_type                  bounds;
   logic [IDX_W-1:0]            tile_col, tile_row;
   logic signed [SCROLL_W-1:0]  scroll_horiz, scroll_vert;
   logic signed [DW-1:0]        pos_x, pos_y;
   logic                        drawn_x, drawn_y, full_x, full_y, visible, partial;
   logic [DEST_W-1:0]           dst_x, dst_y, dest_x, dest_y;
   logic [SRC_W-1:0]            sx, sy, src_x, src_y;
   logic [SIZE_W-1:0]           sw, sh, src_w, src_h;
   logic                        whole_tile;

   assign tile_col     = req_tdata[IDX_W-1:0];
   assign tile_row     = req_tdata[2*IDX_W-1:IDX_W];
   assign scroll_horiz = $signed(req_tdata[2*IDX_W+SCROLL_W-1:2*IDX_W]);
   assign scroll_vert  = $signed(req_tdata[2*IDX_W+2*SCROLL_W-1:2*IDX_W+SCROLL_W]);

   always_comb begin
      en.s5 = !valid_ff[4] || rsp_tready;
      en.s4 = !valid_ff[3] || en.s5;
      en.s3 = !valid_ff[2] || en.s4;
      en.s2 = !valid_ff[1] || en.s3;
      en.s1 = !valid_ff[0] || en.s2;
      valid_in[0] = en.s1 ? req_tvalid  : valid_ff[0];
      valid_in[1] = en.s2 ? valid_ff[0] : valid_ff[1];
      valid_in[2] = en.s3 ? valid_ff[1] : valid_ff[2];
      valid_in[3] = en.s4 ? valid_ff[2] : valid_ff[3];
      valid_in[4] = en.s5 ? valid_ff[3] : valid_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = en.s1;
   assign rsp_tvalid = valid_ff[4];

   tswc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   tswc_wrap u_wrap_x (
      .clock  (clock),
      .en     (en),
      .k      (AXIS_X),
      .idx    (tile_col),
      .scroll (scroll_horiz),
      .origin (bounds.base_x),
      .pos    (pos_x)
   );

   tswc_wrap u_wrap_y (
      .clock  (clock),
      .en     (en),
      .k      (AXIS_Y),
      .idx    (tile_row),
      .scroll (scroll_vert),
      .origin (bounds.base_y),
      .pos    (pos_y)
   );

   tswc_clip u_clip_x (
      .clock (clock),
      .en    (en.s5),
      .pos   (pos_x),
      .tile  (AXIS_X.tile),
      .lo    (bounds.lo_x),
      .hi    (bounds.hi_x),
      .drawn (drawn_x),
      .full  (full_x),
      .dst   (dst_x),
      .src   (sx),
      .size  (sw)
   );

   tswc_clip u_clip_y (
      .clock (clock),
      .en    (en.s5),
      .pos   (pos_y),
      .tile  (AXIS_Y.tile),
      .lo    (bounds.lo_y),
      .hi    (bounds.hi_y),
      .drawn (drawn_y),
      .full  (full_y),
      .dst   (dst_y),
      .src   (sy),
      .size  (sh)
   );

   // everything but visible reads zero when nothing is drawn
   always_comb begin
      visible = drawn_x && drawn_y;
      dest_x  = visible ? dst_x : '0;
      dest_y  = visible ? dst_y : '0;
      src_x   = visible ? sx : '0;
      src_y   = visible ? sy : '0;
      src_w   = visible ? sw : '0;
      src_h   = visible ? sh : '0;
      partial = visible && !(full_x && full_y);
   end

   assign rsp_tdata = {(RSP_DATA_W-RSP_FIELDS_W)'(0), partial, src_h, src_w, src_y, src_x,
                       dest_y, dest_x, visible};

   assign whole_tile = src_w == SIZE_W'(TILE_WIDTH) && src_h == SIZE_W'(TILE_HEIGHT)
                       && src_x == '0 && src_y == '0;

   `TSWC_ASSERT_RST(a_hidden_zero, rsp_tvalid && !visible |-> rsp_tdata == '0, "hidden data")
   `TSWC_ASSERT_RST(a_whole_tile, rsp_tvalid && visible && !partial |-> whole_tile, "whole tile")
   `TSWC_ASSERT(a_reset_empty, $past(reset) |-> !rsp_tvalid, "output valid after reset")

endmodule

// File: dv/tile_scroll_wrap_clip_tb.sv
`timescale 1ns / 1ps

module tile_scroll_wrap_clip_tb import tswc_pkg::*; ();

   localparam logic [ADDR_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [ADDR_W-1:0] REG_SPARE_7 = 3'd7;

   // packed high field first, so the first tdata field lands in the low bits
   typedef struct packed {
      logic signed [SCROLL_W-1:0] scroll_v;
      logic signed [SCROLL_W-1:0] scroll_h;
      logic [IDX_W-1:0]           row;
      logic [IDX_W-1:0]           col;
   } tile_req_type;

   typedef struct packed {
      logic              partial;
      logic [SIZE_W-1:0] src_h;
      logic [SIZE_W-1:0] src_w;
      logic [SRC_W-1:0]  src_y;
      logic [SRC_W-1:0]  src_x;
      logic [DEST_W-1:0] dest_y;
      logic [DEST_W-1:0] dest_x;
      logic              visible;
   } tile_rsp_type;

   typedef struct {
      int col, row, sx, sy;
      bit pinned;
      int vis, dx, dy, ox, oy, w, h, part;
   } probe_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen;
   logic [ADDR_W-1:0]     csr_addr;
   logic [CFG_W-1:0]      csr_wdata;

   logic [CFG_W-1:0] org_x, org_y, clip_l, clip_t, clip_w, clip_h;

   tile_rsp_type placements_due[$];
   int           mismatches = 0;
   bit           send_gapless = 1'b0;
   bit           recv_gapless = 1'b0;
   int           rsp_hold_cycles = 0;

   // col, row, scroll_h, scroll_v, pinned, visible, dx, dy, ox, oy, w, h, partial
   probe_type probes [18] = '{
      '{ 0,  0,      0,      0, 1, 1,   0,   0, 0, 0, 16, 16, 0},
      '{25, 19,      0,      0, 1, 1, 400, 304, 0, 0, 16, 16, 0},
      '{ 0,  0,      8,      0, 1, 1,   0,   0, 8, 0,  8, 16, 1},
      '{ 0,  0,     16,      0, 1, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0,  0,      0,     16, 1, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0,  0,      0,      8, 1, 1,   0,   0, 0, 8, 16,  8, 1},
      '{31, 31,      0,      0, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{26, 20,      0,      0, 1, 1,   0,   0, 0, 0, 16, 16, 0},
      '{ 0,  0, -32768, -32768, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0,  0,  32767,  32767, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{31,  0, -32768,  32767, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0, 31,  32767, -32768, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0,  0,     -1,     -1, 1, 1,   1,   1, 0, 0, 16, 16, 0},
      '{25, 19,     -1,     -1, 1, 1, 401, 305, 0, 0, 15, 15, 1},
      '{ 0,  0,    -17,      0, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{ 0,  0,     17,     17, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{10,  5,  21845, -21846, 0, 0,   0,   0, 0, 0,  0,  0, 0},
      '{21, 10, -21846,  21845, 0, 0,   0,   0, 0, 0,  0,  0, 0}
   };

   tile_scroll_wrap_clip dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint floor_mod(longint a, longint p);
      longint r;
      r = a % p;
      if (r < 0) r += p;
      return r;
   endfunction

   function automatic longint wrap_offset(longint m, longint tile, longint plane);
      if (m >= plane) m = floor_mod(m, plane);
      if (m < -tile) m = floor_mod(m + tile, plane) - tile;
      return m;
   endfunction

   function automatic void clip_span(input longint d, input longint tile, input longint lo,
                                     input longint hi, output longint od, output longint os,
                                     output longint ow);
      os = 0;
      ow = tile;
      if (d < lo) begin
         os = lo - d;
         ow -= os;
         d = lo;
      end
      if (d + ow > hi) ow = hi - d;
      od = d;
   endfunction

   function automatic tile_rsp_type place_tile(tile_req_type t);
      longint       mx, my, bx0, bx1, by0, by1, dx, dy, ox, oy, w, h;
      tile_rsp_type o;
      mx = wrap_offset(longint'(t.col) * TILE_WIDTH - longint'(t.scroll_h),
                       TILE_WIDTH, PLANE_W);
      my = wrap_offset(longint'(t.row) * TILE_HEIGHT - longint'(t.scroll_v),
                       TILE_HEIGHT, PLANE_H);
      bx0 = longint'(org_x);
      by0 = longint'(org_y);
      bx1 = bx0 + PLANE_W;
      by1 = by0 + PLANE_H;
      if (clip_w != 0 && clip_h != 0) begin
         if (longint'(clip_l) > bx0) bx0 = longint'(clip_l);
         if (longint'(clip_t) > by0) by0 = longint'(clip_t);
         if (longint'(clip_l) + longint'(clip_w) < bx1) bx1 = longint'(clip_l) + longint'(clip_w);
         if (longint'(clip_t) + longint'(clip_h) < by1) by1 = longint'(clip_t) + longint'(clip_h);
      end
      clip_span(longint'(org_x) + mx, TILE_WIDTH, bx0, bx1, dx, ox, w);
      clip_span(longint'(org_y) + my, TILE_HEIGHT, by0, by1, dy, oy, h);
      o = '0;
      if (w > 0 && h > 0) begin
         o.visible = 1'b1;
         o.dest_x  = DEST_W'(dx);
         o.dest_y  = DEST_W'(dy);
         o.src_x   = SRC_W'(ox);
         o.src_y   = SRC_W'(oy);
         o.src_w   = SIZE_W'(w);
         o.src_h   = SIZE_W'(h);
         o.partial = (ox != 0 || oy != 0 || w != TILE_WIDTH || h != TILE_HEIGHT);
      end
      return o;
   endfunction

   function automatic logic signed [SCROLL_W-1:0] rand_scroll();
      case ($urandom_range(0, 3))
         0: return SCROLL_W'($urandom);
         1: return SCROLL_W'(int'($urandom_range(0, 1400)) - 700);
         2: return SCROLL_W'(16 * (int'($urandom_range(0, 80)) - 40)
                             + int'($urandom_range(0, 2)) - 1);
         default: return $urandom_range(0, 1) ? SCROLL_W'(32767 - $urandom_range(0, 40))
                                              : SCROLL_W'(32768 + $urandom_range(0, 40));
      endcase
   endfunction

   function automatic tile_req_type rand_tile();
      tile_req_type t;
      t.col = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(26, 31))
                                          : IDX_W'($urandom_range(0, 25));
      t.row = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom_range(20, 31))
                                          : IDX_W'($urandom_range(0, 19));
      t.scroll_h = rand_scroll();
      t.scroll_v = rand_scroll();
      return t;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // entered and left at a falling edge; tvalid stays up for a back-to-back beat
   task automatic send_tile(tile_req_type t, bit pinned, tile_rsp_type pin_rsp);
      int gap;
      gap = send_gapless ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = REQ_DATA_W'(t);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      placements_due.push_back(pinned ? pin_rsp : place_tile(t));
      @(negedge clock);
   endtask

   task automatic write_csr(logic [ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_wen   = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         REG_ORIGIN_X: org_x  = val;
         REG_ORIGIN_Y: org_y  = val;
         REG_CLIP_L:   clip_l = val;
         REG_CLIP_T:   clip_t = val;
         REG_CLIP_W:   clip_w = val;
         REG_CLIP_H:   clip_h = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic program_regs(logic [CFG_W-1:0] ox, logic [CFG_W-1:0] oy,
                               logic [CFG_W-1:0] cl, logic [CFG_W-1:0] ct,
                               logic [CFG_W-1:0] cw, logic [CFG_W-1:0] ch);
      drain();
      write_csr(REG_ORIGIN_X, ox);
      write_csr(REG_ORIGIN_Y, oy);
      write_csr(REG_CLIP_L, cl);
      write_csr(REG_CLIP_T, ct);
      write_csr(REG_CLIP_W, cw);
      write_csr(REG_CLIP_H, ch);
      csr_wen = 1'b0;
   endtask

   task automatic send_random(int n);
      repeat (n) send_tile(rand_tile(), 1'b0, '0);
   endtask

   // result side: random stall per beat, plus one long hold-off on request
   initial begin
      int wait_n;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            for (int c = 0; c < rsp_hold_cycles; c++) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         wait_n = recv_gapless ? 0 : $urandom_range(0, 8);
         if (wait_n > 0) begin
            rsp_tready = 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      tile_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tile_rsp_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
         if (placements_due.size() == 0) begin
            flag_mismatch("beat with nothing due, dest_x", got.dest_x, 0);
         end else begin
            want = placements_due.pop_front();
            if (got.visible != want.visible) flag_mismatch("visible", got.visible, want.visible);
            if (got.dest_x != want.dest_x)   flag_mismatch("dest_x", got.dest_x, want.dest_x);
            if (got.dest_y != want.dest_y)   flag_mismatch("dest_y", got.dest_y, want.dest_y);
            if (got.src_x != want.src_x)     flag_mismatch("src_x", got.src_x, want.src_x);
            if (got.src_y != want.src_y)     flag_mismatch("src_y", got.src_y, want.src_y);
            if (got.src_w != want.src_w)     flag_mismatch("src_w", got.src_w, want.src_w);
            if (got.src_h != want.src_h)     flag_mismatch("src_h", got.src_h, want.src_h);
            if (got.partial != want.partial) flag_mismatch("partial", got.partial, want.partial);
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("tile_scroll_wrap_clip_tb NOT OK");
      $finish;
   end

   initial begin
      tile_req_type t;
      tile_rsp_type pin;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      org_x  = '0;
      org_y  = '0;
      clip_l = '0;
      clip_t = '0;
      clip_w = '0;
      clip_h = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed probes at reset config
      foreach (probes[i]) begin
         t.col      = IDX_W'(probes[i].col);
         t.row      = IDX_W'(probes[i].row);
         t.scroll_h = SCROLL_W'(probes[i].sx);
         t.scroll_v = SCROLL_W'(probes[i].sy);
         pin.visible = probes[i].vis[0];
         pin.dest_x  = DEST_W'(probes[i].dx);
         pin.dest_y  = DEST_W'(probes[i].dy);
         pin.src_x   = SRC_W'(probes[i].ox);
         pin.src_y   = SRC_W'(probes[i].oy);
         pin.src_w   = SIZE_W'(probes[i].w);
         pin.src_h   = SIZE_W'(probes[i].h);
         pin.partial = probes[i].part[0];
         send_tile(t, probes[i].pinned, pin);
      end
      send_random(60);

      // plane at far corner, clipping off, no idling either side
      program_regs(10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0);
      send_gapless = 1'b1;
      recv_gapless = 1'b1;
      send_random(60);
      recv_gapless = 1'b0;

      // clip inside the plane; long result hold-off fills the pipe
      program_regs(10'd100, 10'd50, 10'd150, 10'd120, 10'd200, 10'd100);
      rsp_hold_cycles = 80;
      send_random(40);
      send_gapless = 1'b0;
      send_random(30);

      // clip height zero disables clipping; writes past the register list
      program_regs(10'd5, 10'd7, 10'd300, 10'd40, 10'd700, 10'd0);
      write_csr(REG_SPARE_6, 10'h3ff);
      write_csr(REG_SPARE_7, 10'h155);
      csr_wen = 1'b0;
      send_random(60);

      // clip rectangle misses the plane
      program_regs(10'd0, 10'd0, 10'd1000, 10'd1000, 10'd20, 10'd20);
      send_random(40);

      program_regs(10'd1000, 10'd1000, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_random(60);

      repeat (3) begin
         program_regs(CFG_W'($urandom), CFG_W'($urandom),
                      CFG_W'($urandom_range(0, 600)), CFG_W'($urandom_range(0, 500)),
                      ($urandom_range(0, 4) == 0) ? '0 : CFG_W'($urandom),
                      CFG_W'($urandom));
         send_random(40);
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && placements_due.size() == 0) begin
         $display("tile_scroll_wrap_clip_tb OK");
      end else begin
         $display("tile_scroll_wrap_clip_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/tswc_pkg.sv
design/tswc_cfg.sv
design/tswc_wrap.sv
design/tswc_clip.sv
design/tile_scroll_wrap_clip.sv
dv/tile_scroll_wrap_clip_tb.sv
